### src/psa_pkg.sv
// ----------------------------------------------------------------------------
// Position source arbiter package
// Shared widths, source codes, register indexes and types.
// ----------------------------------------------------------------------------
package psa_pkg;

    localparam int TIME_W      = 32;
    localparam int SRC_W       = 2;
    localparam int NUM_SRC     = 3;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 104;
    localparam int CFG_IDX_W   = 1;

    localparam logic [SRC_W-1:0] SRC_NONE     = 2'd0;
    localparam logic [SRC_W-1:0] SRC_RECEIVER = 2'd1;
    localparam logic [SRC_W-1:0] SRC_PHONE    = 2'd2;
    localparam logic [SRC_W-1:0] SRC_SIM      = 2'd3;

    localparam logic [1:0] SLOT_RECEIVER = 2'd0;
    localparam logic [1:0] SLOT_PHONE    = 2'd1;
    localparam logic [1:0] SLOT_SIM      = 2'd2;

    localparam logic KIND_FEED = 1'b0;
    localparam logic KIND_PICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SIM_HOLD      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RECEIVER_HOLD = 1'd1;

    localparam logic [TIME_W-1:0] AGE_NEVER = {TIME_W{1'b1}};
    localparam logic [TIME_W-1:0] HOLD_RESET = 32'd3000;

    typedef logic [NUM_SRC-1:0][TIME_W-1:0] time_arr_t;

    typedef struct packed {
        logic sim;
        logic phone;
        logic receiver;
    } src_marks_t;

    typedef struct packed {
        logic [TIME_W-1:0] sim_age;
        logic [TIME_W-1:0] phone_age;
        logic [TIME_W-1:0] receiver_age;
        logic [SRC_W-1:0]  chosen;
    } pick_result_t;

endpackage

### src/psa_pick.sv
// ----------------------------------------------------------------------------
// Position source pick logic
// Computes source ages, the chosen source and the consumed fresh marks.
// ----------------------------------------------------------------------------
module psa_pick (
    input  logic [psa_pkg::TIME_W-1:0] now_ms,
    input  logic                       receiver_has_fix,
    input  psa_pkg::time_arr_t         last_seen,
    input  psa_pkg::src_marks_t        fresh,
    input  psa_pkg::src_marks_t        started,
    input  logic [psa_pkg::TIME_W-1:0] sim_hold_ms,
    input  logic [psa_pkg::TIME_W-1:0] receiver_hold_ms,
    output psa_pkg::pick_result_t      result,
    output psa_pkg::src_marks_t        fresh_next
);
    import psa_pkg::*;

    logic [TIME_W-1:0] rcv_age;
    logic [TIME_W-1:0] ph_age;
    logic [TIME_W-1:0] sm_age;
    logic              sim_blocks;
    logic              rcv_blocks;

    assign rcv_age = started.receiver ? now_ms - last_seen[SLOT_RECEIVER] : AGE_NEVER;
    assign ph_age  = started.phone    ? now_ms - last_seen[SLOT_PHONE]    : AGE_NEVER;
    assign sm_age  = started.sim      ? now_ms - last_seen[SLOT_SIM]      : AGE_NEVER;

    assign sim_blocks = sm_age < sim_hold_ms;
    assign rcv_blocks = rcv_age < receiver_hold_ms;

    always_comb
    begin
        result.receiver_age = rcv_age;
        result.phone_age    = ph_age;
        result.sim_age      = sm_age;
        result.chosen       = SRC_NONE;
        fresh_next          = fresh;
        if (fresh.sim)
        begin
            fresh_next.sim = 1'b0;
            result.chosen  = SRC_SIM;
        end
        else if (sim_blocks)
        begin
            fresh_next.receiver = 1'b0;
            fresh_next.phone    = 1'b0;
        end
        else if (fresh.receiver)
        begin
            fresh_next.receiver = 1'b0;
            result.chosen       = SRC_RECEIVER;
        end
        else if (rcv_blocks)
        begin
            fresh_next.phone = 1'b0;
        end
        else if (fresh.phone)
        begin
            fresh_next.phone = 1'b0;
            result.chosen    = receiver_has_fix ? SRC_NONE : SRC_PHONE;
        end
    end

endmodule

### src/position_source_arbiter_core.sv
// ----------------------------------------------------------------------------
// Position source arbiter core
// A pick beat is taken into the input register; its result is then presented from the result register.
// Throughput: one input beat per cycle, feeds and picks alike, unless a pick waits on an unaccepted result.
// The input register and the result register are the two stages.
// Reset clears the source marks, arrival times and handshake state, and
// loads both hold registers with 3000 ms.
// ----------------------------------------------------------------------------
module position_source_arbiter_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [psa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [psa_pkg::TIME_W-1:0]      cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // source [1:0], now_ms [33:2], receiver_has_fix [34], zero fill above
    input  logic [psa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // kind [0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // chosen [1:0], receiver_age [33:2], phone_age [65:34], sim_age [97:66],
    // zero fill above
    output logic [psa_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import psa_pkg::*;

    logic              in_valid_reg;
    logic              in_kind_reg;
    logic [SRC_W-1:0]  in_source_reg;
    logic [TIME_W-1:0] in_now_reg;
    logic              in_fix_reg;

    logic [TIME_W-1:0] sim_hold_reg;
    logic [TIME_W-1:0] receiver_hold_reg;
    time_arr_t         last_seen_reg;
    src_marks_t        fresh_reg;
    src_marks_t        started_reg;
    src_marks_t        fresh_next;

    logic              out_valid_reg;
    pick_result_t      out_result_reg;
    pick_result_t      pick_result;
    src_marks_t        pick_fresh;

    logic              advance;
    logic              in_fire;
    logic              feed_fire;
    logic              pick_fire;
    logic [1:0]        feed_slot;

    assign advance   = in_valid_reg
                       && (in_kind_reg == KIND_FEED || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign feed_fire = advance && in_kind_reg == KIND_FEED && in_source_reg != SRC_NONE;
    assign pick_fire = advance && in_kind_reg == KIND_PICK;
    assign feed_slot = in_source_reg - 2'd1;

    psa_pick u_pick (
        .now_ms           (in_now_reg),
        .receiver_has_fix (in_fix_reg),
        .last_seen        (last_seen_reg),
        .fresh            (fresh_reg),
        .started          (started_reg),
        .sim_hold_ms      (sim_hold_reg),
        .receiver_hold_ms (receiver_hold_reg),
        .result           (pick_result),
        .fresh_next       (pick_fresh)
    );

    always_comb
    begin
        fresh_next = fresh_reg;
        if (pick_fire)
        begin
            fresh_next = pick_fresh;
        end
        else if (feed_fire)
        begin
            case (in_source_reg)
                SRC_RECEIVER: fresh_next.receiver = 1'b1;
                SRC_PHONE:    fresh_next.phone    = 1'b1;
                SRC_SIM:      fresh_next.sim      = 1'b1;
                default:      fresh_next          = fresh_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sim_hold_reg      <= HOLD_RESET;
            receiver_hold_reg <= HOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SIM_HOLD:      sim_hold_reg      <= cfg_data;
                REG_RECEIVER_HOLD: receiver_hold_reg <= cfg_data;
                default:           sim_hold_reg      <= sim_hold_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_kind_reg   <= s_axis_tuser;
            in_source_reg <= s_axis_tdata[1:0];
            in_now_reg    <= s_axis_tdata[33:2];
            in_fix_reg    <= s_axis_tdata[34];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_seen_reg <= '0;
            fresh_reg     <= '0;
            started_reg   <= '0;
        end
        else
        begin
            fresh_reg <= fresh_next;
            if (feed_fire)
            begin
                last_seen_reg[feed_slot] <= in_now_reg;
                case (in_source_reg)
                    SRC_RECEIVER: started_reg.receiver <= 1'b1;
                    SRC_PHONE:    started_reg.phone    <= 1'b1;
                    SRC_SIM:      started_reg.sim      <= 1'b1;
                    default:      started_reg          <= started_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pick_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pick_fire)
        begin
            out_result_reg <= pick_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(pick_result_t)){1'b0}}, out_result_reg};

    a_sim_win_consumes: assert property (@(posedge clk) disable iff (!rst_n)
        (pick_fire && pick_result.chosen == SRC_SIM) |=> !fresh_reg.sim)
        else $error("simulated fresh mark survived a simulated win");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input stalled with an empty input register");

    a_result_from_pick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(pick_fire))
        else $error("result beat raised without a pick");

    a_feed_starts_source: assert property (@(posedge clk) disable iff (!rst_n)
        (feed_fire && in_source_reg == SRC_RECEIVER) |=> started_reg.receiver)
        else $error("receiver feed did not start the receiver");

endmodule
